>>> rtl/ies_pkg.sv
package ies_pkg;

   // beam sensor level that means "triggered"
   localparam logic SENSOR_ACTIVE_LEVEL = 1'b0;
   localparam int COUNT_WIDTH = 16;
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   localparam int REG_COUNT = 8;
   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_CONTROL_MODE    = 3'd0,
      REG_OPEN_LOOP_SPEED = 3'd1,
      REG_SPEED_LIFT      = 3'd2,
      REG_SPEED_START     = 3'd3,
      REG_SPEED_CATCH     = 3'd4,
      REG_SPEED_IDLE      = 3'd5,
      REG_SPEED_DROP      = 3'd6,
      REG_DROP_TICKS      = 3'd7
   } ies_reg_type;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_ASK_CATCH  = 2'd1,
      CMD_ASK_DROP   = 2'd2,
      CMD_STOP_ASK   = 2'd3
   } ies_cmd_type;

   localparam logic [1:0] RUMBLE_NONE    = 2'd0;
   localparam logic [1:0] RUMBLE_CAUGHT  = 2'd1;
   localparam logic [1:0] RUMBLE_DROPPED = 2'd2;

   localparam logic [2:0] PHASE_CODE_REST     = 3'd0;
   localparam logic [2:0] PHASE_CODE_START    = 3'd1;
   localparam logic [2:0] PHASE_CODE_CATCHING = 3'd2;
   localparam logic [2:0] PHASE_CODE_CAUGHT   = 3'd3;
   localparam logic [2:0] PHASE_CODE_DROPPING = 3'd4;

   typedef enum logic [4:0] {
      PH_REST     = 5'b00001,
      PH_START    = 5'b00010,
      PH_CATCHING = 5'b00100,
      PH_CAUGHT   = 5'b01000,
      PH_DROPPING = 5'b10000
   } ies_phase_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       sensor_low;
      logic       sensor_high_a;
      logic       sensor_high_b;
   } ies_req_type;

   typedef struct packed {
      logic signed [15:0] motor_command;
      logic [2:0]         phase;
      logic               is_caught;
      logic               is_dropped;
      logic [1:0]         rumble_kind;
   } ies_rsp_type;

   typedef struct packed {
      logic               control_mode;
      logic signed [15:0] open_loop_speed;
      logic signed [15:0] speed_lift;
      logic signed [15:0] speed_start;
      logic signed [15:0] speed_catch;
      logic signed [15:0] speed_idle;
      logic signed [15:0] speed_drop;
      logic [15:0]        drop_ticks;
   } ies_cfg_type;

   function automatic logic [2:0] phase_code(ies_phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_REST:     code = PHASE_CODE_REST;
         PH_START:    code = PHASE_CODE_START;
         PH_CATCHING: code = PHASE_CODE_CATCHING;
         PH_CAUGHT:   code = PHASE_CODE_CAUGHT;
         PH_DROPPING: code = PHASE_CODE_DROPPING;
         default:     code = PHASE_CODE_REST;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/ies_core.sv
module ies_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ies_pkg::ies_req_type item,
   input  ies_pkg::ies_cfg_type cfg,
   output ies_pkg::ies_rsp_type result
);

   localparam logic [ies_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

   ies_pkg::ies_phase_type          phase_ff, phase_in;
   logic                            catch_wanted_ff, catch_wanted_in;
   logic                            drop_wanted_ff, drop_wanted_in;
   logic [ies_pkg::COUNT_WIDTH-1:0] drop_count_ff, drop_count_in;
   logic signed [15:0]              motor_hold_ff, motor_hold_in;
   logic [1:0]                      rumble;
   logic                            low, high, drop_done;
   logic [ies_pkg::CMP_WIDTH-1:0]   count_cmp, ticks_cmp;

   assign low  = (item.sensor_low == ies_pkg::SENSOR_ACTIVE_LEVEL);
   assign high = (item.sensor_high_a == ies_pkg::SENSOR_ACTIVE_LEVEL) ||
                 (item.sensor_high_b == ies_pkg::SENSOR_ACTIVE_LEVEL);

   assign count_cmp = ies_pkg::CMP_WIDTH'(drop_count_ff);
   assign ticks_cmp = ies_pkg::CMP_WIDTH'(cfg.drop_ticks);
   assign drop_done = (count_cmp > ticks_cmp);

   always_comb begin
      phase_in        = phase_ff;
      catch_wanted_in = catch_wanted_ff;
      drop_wanted_in  = drop_wanted_ff;
      drop_count_in   = drop_count_ff;
      motor_hold_in   = motor_hold_ff;
      rumble          = ies_pkg::RUMBLE_NONE;
      case (ies_pkg::ies_cmd_type'(item.cmd))
         ies_pkg::CMD_TICK: begin
            if (cfg.control_mode) begin
               motor_hold_in = cfg.open_loop_speed;
            end else begin
               case (phase_ff)
                  ies_pkg::PH_REST: begin
                     if (low) begin
                        phase_in        = ies_pkg::PH_START;
                        motor_hold_in   = high ? cfg.speed_start : cfg.speed_lift;
                        catch_wanted_in = 1'b1;
                     end else if (catch_wanted_ff) begin
                        phase_in      = ies_pkg::PH_START;
                        motor_hold_in = cfg.speed_start;
                     end
                  end
                  ies_pkg::PH_START: begin
                     if (high) begin
                        phase_in      = ies_pkg::PH_CATCHING;
                        motor_hold_in = cfg.speed_catch;
                     end else if (!catch_wanted_ff) begin
                        phase_in      = ies_pkg::PH_REST;
                        motor_hold_in = cfg.speed_idle;
                     end
                  end
                  ies_pkg::PH_CATCHING: begin
                     if (low && !high) begin
                        phase_in        = ies_pkg::PH_CAUGHT;
                        motor_hold_in   = cfg.speed_idle;
                        catch_wanted_in = 1'b0;
                        rumble          = ies_pkg::RUMBLE_CAUGHT;
                     end
                  end
                  ies_pkg::PH_CAUGHT: begin
                     if (drop_wanted_ff) begin
                        phase_in      = ies_pkg::PH_DROPPING;
                        motor_hold_in = cfg.speed_drop;
                        drop_count_in = '0;
                     end
                  end
                  ies_pkg::PH_DROPPING: begin
                     if (!low) begin
                        if (drop_done) begin
                           phase_in      = ies_pkg::PH_REST;
                           motor_hold_in = cfg.speed_idle;
                           drop_count_in = '0;
                           rumble        = ies_pkg::RUMBLE_DROPPED;
                        end else if (drop_count_ff != COUNT_MAX) begin
                           drop_count_in = drop_count_ff + 1'b1;
                        end
                     end else if (!drop_wanted_ff) begin
                        // beam blocked again with no drop asked: lift it back in
                        phase_in        = ies_pkg::PH_START;
                        motor_hold_in   = cfg.speed_lift;
                        catch_wanted_in = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         ies_pkg::CMD_ASK_CATCH: begin
            if (phase_ff == ies_pkg::PH_REST) catch_wanted_in = 1'b1;
         end
         ies_pkg::CMD_ASK_DROP: begin
            if (phase_ff == ies_pkg::PH_CAUGHT) drop_wanted_in = 1'b1;
         end
         default: begin
            catch_wanted_in = 1'b0;
            drop_wanted_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ies_pkg::PH_REST;
         catch_wanted_ff <= 1'b0;
         drop_wanted_ff  <= 1'b0;
         drop_count_ff   <= '0;
         motor_hold_ff   <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         catch_wanted_ff <= catch_wanted_in;
         drop_wanted_ff  <= drop_wanted_in;
         drop_count_ff   <= drop_count_in;
         motor_hold_ff   <= motor_hold_in;
      end
   end

   always_comb begin
      result.motor_command = motor_hold_in;
      result.phase         = ies_pkg::phase_code(phase_in);
      result.is_caught     = (phase_in == ies_pkg::PH_CAUGHT);
      result.is_dropped    = (phase_in == ies_pkg::PH_REST);
      result.rumble_kind   = rumble;
   end

endmodule

>>> rtl/intake_eject_sequencer_unit.sv
// Load and eject sequencer for one motor. Every beat on req_ (a tick with
// raw beam levels, or a catch, drop or stop-asking request) yields exactly
// one beat on rsp_ the cycle after acceptance, from an output register.
// One beat is taken per clock; req_stall rises only while a result is held
// and rsp_stall is high, set by that single output register. Registers are
// written over the csr_ port at byte address 4*index and read back there.
module intake_eject_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ies_pkg::ies_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ies_pkg::ies_rsp_type             rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ies_pkg::ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [ies_pkg::DATA_WIDTH-1:0]   csr_pwdata,
   output logic [ies_pkg::DATA_WIDTH-1:0]   csr_prdata,
   output logic                             csr_pready
);

   ies_pkg::ies_cfg_type cfg_ff;
   ies_pkg::ies_rsp_type result;
   ies_pkg::ies_rsp_type rsp_data_ff;
   ies_pkg::ies_reg_type reg_sel;
   logic                 rsp_valid_ff;
   logic                 fire, csr_write;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;

   ies_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = ies_pkg::ies_reg_type'(csr_paddr[ies_pkg::ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{drop_ticks: 16'd25, default: '0};
      end else if (csr_write) begin
         case (reg_sel)
            ies_pkg::REG_CONTROL_MODE:    cfg_ff.control_mode    <= csr_pwdata[0];
            ies_pkg::REG_OPEN_LOOP_SPEED: cfg_ff.open_loop_speed <= csr_pwdata[15:0];
            ies_pkg::REG_SPEED_LIFT:      cfg_ff.speed_lift      <= csr_pwdata[15:0];
            ies_pkg::REG_SPEED_START:     cfg_ff.speed_start     <= csr_pwdata[15:0];
            ies_pkg::REG_SPEED_CATCH:     cfg_ff.speed_catch     <= csr_pwdata[15:0];
            ies_pkg::REG_SPEED_IDLE:      cfg_ff.speed_idle      <= csr_pwdata[15:0];
            ies_pkg::REG_SPEED_DROP:      cfg_ff.speed_drop      <= csr_pwdata[15:0];
            ies_pkg::REG_DROP_TICKS:      cfg_ff.drop_ticks      <= csr_pwdata[15:0];
            default:                      cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ies_pkg::REG_CONTROL_MODE:
            csr_prdata = {{(ies_pkg::DATA_WIDTH-1){1'b0}}, cfg_ff.control_mode};
         ies_pkg::REG_OPEN_LOOP_SPEED: csr_prdata = {16'd0, cfg_ff.open_loop_speed};
         ies_pkg::REG_SPEED_LIFT:      csr_prdata = {16'd0, cfg_ff.speed_lift};
         ies_pkg::REG_SPEED_START:     csr_prdata = {16'd0, cfg_ff.speed_start};
         ies_pkg::REG_SPEED_CATCH:     csr_prdata = {16'd0, cfg_ff.speed_catch};
         ies_pkg::REG_SPEED_IDLE:      csr_prdata = {16'd0, cfg_ff.speed_idle};
         ies_pkg::REG_SPEED_DROP:      csr_prdata = {16'd0, cfg_ff.speed_drop};
         ies_pkg::REG_DROP_TICKS:      csr_prdata = {16'd0, cfg_ff.drop_ticks};
         default:                      csr_prdata = '0;
      endcase
   end

endmodule

>>> bench/intake_eject_sequencer_unit_test.sv
`timescale 1ns / 100ps

module intake_eject_sequencer_unit_test;
   import ies_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS = 180;
   localparam logic BEAM_HIT = SENSOR_ACTIVE_LEVEL;
   localparam logic BEAM_CLR = ~SENSOR_ACTIVE_LEVEL;
   localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;

   typedef struct {
      ies_req_type item;
      bit          typed;
      ies_rsp_type want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ies_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ies_rsp_type           rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [DATA_WIDTH-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the sequencer: settings and state
   ies_cfg_type        cfg_shadow;
   logic [2:0]         seq_phase;
   bit                 seq_catch_want;
   bit                 seq_drop_want;
   longint             seq_drop_cnt;
   logic signed [15:0] seq_motor;

   ies_rsp_type pending_reports[$];
   ies_rsp_type want_rsp;
   int          mismatches = 0;
   int          items_sent = 0;
   int          reports_checked = 0;
   int          settings_loaded = 0;
   int          gap_max = 3;
   bit          rx_quiet = 1'b0;
   bit          long_hold_request = 1'b0;
   int          stall_left = 0;
   int          rx_draw;
   int          quiet_cycles = 0;

   dir_row_type dir_rows[26] = '{
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh0000, PHASE_CODE_REST, 1'b0, 1'b1, RUMBLE_NONE}},
      '{'{CMD_ASK_DROP, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh0000, PHASE_CODE_REST, 1'b0, 1'b1, RUMBLE_NONE}},
      '{'{CMD_ASK_CATCH, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh0000, PHASE_CODE_REST, 1'b0, 1'b1, RUMBLE_NONE}},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh7fff, PHASE_CODE_START, 1'b0, 1'b0, RUMBLE_NONE}},
      '{'{CMD_TICK, BEAM_CLR, BEAM_HIT, BEAM_CLR}, 1'b1,
        '{16'sh1234, PHASE_CODE_CATCHING, 1'b0, 1'b0, RUMBLE_NONE}},
      '{'{CMD_TICK, BEAM_HIT, BEAM_CLR, BEAM_HIT}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_HIT, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'shffff, PHASE_CODE_CAUGHT, 1'b1, 1'b0, RUMBLE_CAUGHT}},
      '{'{CMD_ASK_CATCH, BEAM_HIT, BEAM_HIT, BEAM_HIT}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_ASK_DROP, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh0001, PHASE_CODE_DROPPING, 1'b0, 1'b0, RUMBLE_NONE}},
      '{'{CMD_TICK, BEAM_CLR, BEAM_HIT, BEAM_HIT}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      // blocked lower beam while the drop request lingers: no abort
      '{'{CMD_TICK, BEAM_HIT, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'shffff, PHASE_CODE_REST, 1'b0, 1'b1, RUMBLE_DROPPED}},
      '{'{CMD_TICK, BEAM_HIT, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh8000, PHASE_CODE_START, 1'b0, 1'b0, RUMBLE_NONE}},
      '{'{CMD_STOP_ASK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_HIT, BEAM_HIT, BEAM_HIT}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_HIT}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_HIT, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_ASK_DROP, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_TICK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      '{'{CMD_STOP_ASK, BEAM_CLR, BEAM_CLR, BEAM_CLR}, 1'b0, '0},
      // drop aborted: lower beam blocked with no drop request
      '{'{CMD_TICK, BEAM_HIT, BEAM_CLR, BEAM_CLR}, 1'b1,
        '{16'sh8000, PHASE_CODE_START, 1'b0, 1'b0, RUMBLE_NONE}}
   };

   intake_eject_sequencer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic beam(bit hit);
      return hit ? BEAM_HIT : BEAM_CLR;
   endfunction

   function automatic void enter(logic [2:0] next_phase, logic signed [15:0] speed);
      seq_phase = next_phase;
      seq_motor = speed;
   endfunction

   function automatic ies_rsp_type advance_sequencer(ies_req_type it);
      bit          low;
      bit          high;
      logic [1:0]  rumble;
      ies_rsp_type r;
      low = (it.sensor_low == SENSOR_ACTIVE_LEVEL);
      high = (it.sensor_high_a == SENSOR_ACTIVE_LEVEL) ||
             (it.sensor_high_b == SENSOR_ACTIVE_LEVEL);
      rumble = RUMBLE_NONE;
      case (ies_cmd_type'(it.cmd))
         CMD_TICK: begin
            if (cfg_shadow.control_mode) begin
               seq_motor = cfg_shadow.open_loop_speed;
            end else begin
               case (seq_phase)
                  PHASE_CODE_REST: begin
                     if (low && !high) begin
                        enter(PHASE_CODE_START, cfg_shadow.speed_lift);
                        seq_catch_want = 1'b1;
                     end else if (low) begin
                        enter(PHASE_CODE_START, cfg_shadow.speed_start);
                        seq_catch_want = 1'b1;
                     end else if (seq_catch_want) begin
                        enter(PHASE_CODE_START, cfg_shadow.speed_start);
                     end
                  end
                  PHASE_CODE_START: begin
                     if (high) enter(PHASE_CODE_CATCHING, cfg_shadow.speed_catch);
                     else if (!seq_catch_want) enter(PHASE_CODE_REST, cfg_shadow.speed_idle);
                  end
                  PHASE_CODE_CATCHING: begin
                     if (low && !high) begin
                        enter(PHASE_CODE_CAUGHT, cfg_shadow.speed_idle);
                        seq_catch_want = 1'b0;
                        rumble = RUMBLE_CAUGHT;
                     end
                  end
                  PHASE_CODE_CAUGHT: begin
                     if (seq_drop_want) begin
                        enter(PHASE_CODE_DROPPING, cfg_shadow.speed_drop);
                        seq_drop_cnt = 0;
                     end
                  end
                  PHASE_CODE_DROPPING: begin
                     if (!low) begin
                        if (seq_drop_cnt > longint'(cfg_shadow.drop_ticks)) begin
                           enter(PHASE_CODE_REST, cfg_shadow.speed_idle);
                           seq_drop_cnt = 0;
                           rumble = RUMBLE_DROPPED;
                        end else if (seq_drop_cnt < COUNT_MAX) begin
                           seq_drop_cnt++;
                        end
                     end else if (!seq_drop_want) begin
                        enter(PHASE_CODE_START, cfg_shadow.speed_lift);
                        seq_catch_want = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_ASK_CATCH: if (seq_phase == PHASE_CODE_REST) seq_catch_want = 1'b1;
         CMD_ASK_DROP: if (seq_phase == PHASE_CODE_CAUGHT) seq_drop_want = 1'b1;
         default: begin
            seq_catch_want = 1'b0;
            seq_drop_want = 1'b0;
         end
      endcase
      r.motor_command = seq_motor;
      r.phase = seq_phase;
      r.is_caught = (seq_phase == PHASE_CODE_CAUGHT);
      r.is_dropped = (seq_phase == PHASE_CODE_REST);
      r.rumble_kind = rumble;
      return r;
   endfunction

   // mostly items that push the current phase onward, some pure noise
   function automatic ies_req_type pick_item(int noise_pct);
      ies_req_type it;
      int          roll;
      logic [1:0]  upper;
      it.cmd = CMD_TICK;
      it.sensor_low = beam(1'b0);
      upper = 2'($urandom_range(3));
      roll = $urandom_range(9);
      if ($urandom_range(99) < noise_pct) begin
         it.cmd = 2'($urandom_range(3));
         it.sensor_low = 1'($urandom_range(1));
         it.sensor_high_a = 1'($urandom_range(1));
         it.sensor_high_b = 1'($urandom_range(1));
         return it;
      end
      case (seq_phase)
         PHASE_CODE_REST: begin
            if (roll < 4 && !seq_catch_want) it.cmd = CMD_ASK_CATCH;
            else if (roll < 7) it.sensor_low = beam(1'b1);
         end
         PHASE_CODE_START: begin
            it.sensor_low = 1'($urandom_range(1));
            if (roll < 8) upper = 2'($urandom_range(1, 3));
            else upper = 2'b00;
         end
         PHASE_CODE_CATCHING: begin
            if (roll < 7) begin
               it.sensor_low = beam(1'b1);
               upper = 2'b00;
            end
         end
         PHASE_CODE_CAUGHT: if (roll < 7 && !seq_drop_want) it.cmd = CMD_ASK_DROP;
         PHASE_CODE_DROPPING: begin
            if (roll == 8) it.sensor_low = beam(1'b1);
            else if (roll == 9) it.cmd = CMD_STOP_ASK;
         end
         default: ;
      endcase
      it.sensor_high_a = beam(upper[0]);
      it.sensor_high_b = beam(upper[1]);
      return it;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_item(ies_req_type it, bit typed, ies_rsp_type want, int gap);
      ies_rsp_type got;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      got = advance_sequencer(it);
      pending_reports.push_back(typed ? want : got);
      items_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(ies_reg_type idx, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_WIDTH'(int'(idx) * 4);
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CONTROL_MODE:    cfg_shadow.control_mode = data[0];
         REG_OPEN_LOOP_SPEED: cfg_shadow.open_loop_speed = data[15:0];
         REG_SPEED_LIFT:      cfg_shadow.speed_lift = data[15:0];
         REG_SPEED_START:     cfg_shadow.speed_start = data[15:0];
         REG_SPEED_CATCH:     cfg_shadow.speed_catch = data[15:0];
         REG_SPEED_IDLE:      cfg_shadow.speed_idle = data[15:0];
         REG_SPEED_DROP:      cfg_shadow.speed_drop = data[15:0];
         default:             cfg_shadow.drop_ticks = data[15:0];
      endcase
      @(posedge clock);
   endtask

   // upper data bits are junk on purpose, only the low field counts
   task automatic load_settings(ies_cfg_type s);
      write_reg(REG_CONTROL_MODE, {31'($urandom), s.control_mode});
      write_reg(REG_OPEN_LOOP_SPEED, {16'($urandom), s.open_loop_speed});
      write_reg(REG_SPEED_LIFT, {16'($urandom), s.speed_lift});
      write_reg(REG_SPEED_START, {16'($urandom), s.speed_start});
      write_reg(REG_SPEED_CATCH, {16'($urandom), s.speed_catch});
      write_reg(REG_SPEED_IDLE, {16'($urandom), s.speed_idle});
      write_reg(REG_SPEED_DROP, {16'($urandom), s.speed_drop});
      write_reg(REG_DROP_TICKS, {16'($urandom), s.drop_ticks});
      settings_loaded++;
   endtask

   // result side: check each beat, then draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, motor %0d phase %0d", $time,
                     rsp_data.motor_command, rsp_data.phase);
            mismatches++;
         end else begin
            want_rsp = pending_reports.pop_front();
            check_field("motor_command", int'(want_rsp.motor_command),
                        int'(rsp_data.motor_command));
            check_field("phase", want_rsp.phase, rsp_data.phase);
            check_field("is_caught", want_rsp.is_caught, rsp_data.is_caught);
            check_field("is_dropped", want_rsp.is_dropped, rsp_data.is_dropped);
            check_field("rumble_kind", want_rsp.rumble_kind, rsp_data.rumble_kind);
            reports_checked++;
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            stall_left <= LONG_HOLD_CYCLES;
         end else begin
            rx_draw = rx_quiet ? 0 : $urandom_range(3);
            if (rx_draw > 0) begin
               rsp_stall <= 1'b1;
               stall_left <= rx_draw;
            end
         end
      end else if (stall_left > 0) begin
         if (stall_left == 1) rsp_stall <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         rsp_stall <= 1'b1;
         stall_left <= LONG_HOLD_CYCLES;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      ies_cfg_type     s;
      ies_req_type     it;
      logic [15:0]     tick_sweep[8];
      int              tries;
      tick_sweep = '{16'd0, 16'd3, 16'hffff, 16'd1, 16'd5, 16'd2, 16'd7, 16'd4};
      cfg_shadow = '0;
      cfg_shadow.drop_ticks = 16'd25;
      seq_phase = PHASE_CODE_REST;
      seq_catch_want = 1'b0;
      seq_drop_want = 1'b0;
      seq_drop_cnt = 0;
      seq_motor = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      s.control_mode = 1'b0;
      s.open_loop_speed = 16'sh5a5a;
      s.speed_lift = 16'sh8000;
      s.speed_start = 16'sh7fff;
      s.speed_catch = 16'sh1234;
      s.speed_idle = 16'shffff;
      s.speed_drop = 16'sh0001;
      s.drop_ticks = 16'd2;
      load_settings(s);
      foreach (dir_rows[i])
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, $urandom_range(3));
      go_idle();

      for (int p = 0; p < 8; p++) begin
         s.control_mode = (p == 3 || p == 6);
         s.open_loop_speed = (p == 3) ? 16'sh8000 : (p == 6) ? 16'sh7fff : 16'($urandom);
         if (p == 1) begin
            s.speed_lift = 16'sh8000;
            s.speed_start = 16'sh7fff;
            s.speed_catch = 16'sh8000;
            s.speed_idle = 16'sh7fff;
            s.speed_drop = 16'sh0000;
         end else begin
            s.speed_lift = 16'($urandom);
            s.speed_start = 16'($urandom);
            s.speed_catch = 16'($urandom);
            s.speed_idle = 16'($urandom);
            s.speed_drop = 16'($urandom);
         end
         s.drop_ticks = tick_sweep[p];
         load_settings(s);
         gap_max = (p == 4) ? 0 : 3;
         rx_quiet = (p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 60) begin
               // receiver holds off while beats keep coming, then drain fully
               long_hold_request = 1'b1;
               repeat (12) send_item(pick_item(15), 1'b0, '0, 0);
               go_idle();
            end
            send_item(pick_item(15), 1'b0, '0, $urandom_range(gap_max));
         end
         go_idle();
      end

      // one long drop held open by a clear lower beam
      s.control_mode = 1'b0;
      s.drop_ticks = 16'd60;
      load_settings(s);
      rx_quiet = 1'b1;
      tries = 0;
      while (seq_phase != PHASE_CODE_DROPPING && tries < 200) begin
         send_item(pick_item(0), 1'b0, '0, 0);
         tries++;
      end
      it.cmd = CMD_TICK;
      it.sensor_low = BEAM_CLR;
      it.sensor_high_a = BEAM_CLR;
      it.sensor_high_b = BEAM_CLR;
      while (seq_phase == PHASE_CODE_DROPPING) send_item(it, 1'b0, '0, 0);
      go_idle();

      $display("run covered %0d items, %0d reports checked, %0d register settings",
               items_sent, reports_checked, settings_loaded);
      $display("both loop modes, long output hold-off and a long clear-beam drop included");
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
